@@ design/indexed_shifting_list_core_macros.svh @@
// Assertion macros shared by the checker files of the indexed shifting list.
`ifndef INDEXED_SHIFTING_LIST_CORE_MACROS_SVH
`define INDEXED_SHIFTING_LIST_CORE_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define ISL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ISL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/isl_pkg.sv @@
// Shared constants, codes and the cell command type of the indexed shifting list.
package isl_pkg;

  localparam int Depth     = 64;
  localparam int WordWidth = 32;

  localparam int ReqW   = 3;
  localparam int IdxW   = 7;
  localparam int ValueW = 32;
  localparam int StW    = 2;
  localparam int CntW   = 7;

  localparam int PosW = (Depth > 1) ? $clog2(Depth) : 1;
  // Width wide enough for both a cell position and a request index.
  localparam int CmpW = (PosW > IdxW) ? PosW : IdxW;

  typedef enum logic [ReqW-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_GET    = 3'd3,
    REQ_SET    = 3'd4,
    REQ_SWAP   = 3'd5
  } req_e;

  typedef enum logic [StW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_SWAP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [CmpW-1:0]      idx_a;
    logic [CmpW-1:0]      idx_b;
    logic [WordWidth-1:0] val_a;
    logic [WordWidth-1:0] val_b;
  } cmd_t;

endpackage

@@ design/indexed_shifting_list_core.sv @@
// Top level of the indexed shifting list: request control, live count and result register.
//
// The list keeps up to Depth handle words in a row of cells, one entry per
// cell, and a live count. A request is taken only when the control is idle.
// For append, insert, remove and set, the control first registers the
// request, then shifts or loads every cell at once in its execute state, and
// then loads the result register in its final state. Only then is it idle
// again, so it takes no new request before the last one has reached the
// result register. Get runs through the same states; the entry is picked off
// a read bus that each cell drives when its position matches the index. Swap
// also passes through a swap state, because both entries are first read into
// registers and then written back crosswise in a second cell step. The result
// register is separate from the control, so a finished result may wait for
// out_ready_i while the next request is already being accepted; the control
// only stalls in its final state if the previous result has not yet been
// taken. Entry cells have no reset; only the live count, the control state
// and the result valid flag are cleared.
module indexed_shifting_list_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [isl_pkg::ReqW-1:0]     req_type_i,
  input  logic [isl_pkg::IdxW-1:0]     index_i,
  input  logic [isl_pkg::IdxW-1:0]     index_b_i,
  input  logic [isl_pkg::ValueW-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [isl_pkg::ValueW-1:0]   read_value_o,
  output logic [isl_pkg::StW-1:0]      status_o,
  output logic [isl_pkg::CntW-1:0]     count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_DONE
  } state_e;

  state_e                        state_q;
  logic [isl_pkg::ReqW-1:0]      req_q;
  logic [isl_pkg::IdxW-1:0]      idx_a_q;
  logic [isl_pkg::IdxW-1:0]      idx_b_q;
  logic [isl_pkg::WordWidth-1:0] val_q;
  logic [isl_pkg::CntW-1:0]      count_q;
  logic [isl_pkg::StW-1:0]       status_q;
  logic [isl_pkg::WordWidth-1:0] rd_a_q;
  logic [isl_pkg::WordWidth-1:0] rd_b_q;

  logic                          out_valid_q;
  logic [isl_pkg::ValueW-1:0]    read_value_q;
  logic [isl_pkg::StW-1:0]       status_out_q;
  logic [isl_pkg::CntW-1:0]      count_out_q;

  isl_pkg::cmd_t                 cmd;
  logic [isl_pkg::WordWidth-1:0] rd_a, rd_b;
  logic [63:0]                   value_wide;
  logic [63:0]                   rd_wide;
  logic                          full, a_in, b_in, ins_in;
  logic [isl_pkg::StW-1:0]       status_d;
  logic [isl_pkg::CntW-1:0]      count_d;
  logic                          is_swap_ok;
  logic                          out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // Values beyond the entry width are dropped on entry.
  assign value_wide = 64'(value_i);
  assign rd_wide    = 64'(rd_a_q);

  assign full   = (32'(count_q) >= 32'(isl_pkg::Depth));
  assign a_in   = (idx_a_q < count_q);
  assign b_in   = (idx_b_q < count_q);
  assign ins_in = (idx_a_q <= count_q);

  // Status and new count of the request held in the control.
  always_comb begin
    status_d   = isl_pkg::ST_DONE;
    count_d    = count_q;
    is_swap_ok = 1'b0;
    unique case (req_q)
      isl_pkg::REQ_APPEND: begin
        if (full) status_d = isl_pkg::ST_FULL;
        else count_d = count_q + 1'b1;
      end
      isl_pkg::REQ_INSERT: begin
        if (!ins_in) status_d = isl_pkg::ST_RANGE;
        else if (full) status_d = isl_pkg::ST_FULL;
        else count_d = count_q + 1'b1;
      end
      isl_pkg::REQ_REMOVE: begin
        if (!a_in) status_d = isl_pkg::ST_RANGE;
        else count_d = count_q - 1'b1;
      end
      isl_pkg::REQ_GET, isl_pkg::REQ_SET: begin
        if (!a_in) status_d = isl_pkg::ST_RANGE;
      end
      isl_pkg::REQ_SWAP: begin
        if (!a_in || !b_in) status_d = isl_pkg::ST_RANGE;
        else is_swap_ok = 1'b1;
      end
      default: status_d = isl_pkg::ST_DONE;
    endcase
  end

  // Command broadcast to the cells. The read buses follow the indexes in every
  // state but the execution of an append, so get and swap pick up their entries during execution.
  always_comb begin
    cmd.kind  = isl_pkg::CMD_NONE;
    cmd.idx_a = isl_pkg::CmpW'(idx_a_q);
    cmd.idx_b = isl_pkg::CmpW'(idx_b_q);
    cmd.val_a = val_q;
    cmd.val_b = val_q;
    if (state_q == S_EXEC && status_d == isl_pkg::ST_DONE) begin
      unique case (req_q)
        isl_pkg::REQ_APPEND: begin
          cmd.kind  = isl_pkg::CMD_WRITE;
          cmd.idx_a = isl_pkg::CmpW'(count_q);
        end
        isl_pkg::REQ_INSERT: cmd.kind = isl_pkg::CMD_INSERT;
        isl_pkg::REQ_REMOVE: cmd.kind = isl_pkg::CMD_REMOVE;
        isl_pkg::REQ_SET:    cmd.kind = isl_pkg::CMD_WRITE;
        default:             cmd.kind = isl_pkg::CMD_NONE;
      endcase
    end else if (state_q == S_SWAP) begin
      cmd.kind  = isl_pkg::CMD_SWAP;
      cmd.val_a = rd_b_q;
      cmd.val_b = rd_a_q;
    end
  end

  isl_row u_row (
    .clk_i  (clk_i),
    .cmd_i  (cmd),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In the final state the result register is either reloaded or held,
      // so the taken result is only cleared in the other states.
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= req_type_i;
            idx_a_q <= index_i;
            idx_b_q <= index_b_i;
            val_q   <= value_wide[isl_pkg::WordWidth-1:0];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_a_q   <= rd_a;
          rd_b_q   <= rd_b;
          status_q <= status_d;
          count_q  <= count_d;
          state_q  <= is_swap_ok ? S_SWAP : S_DONE;
        end
        S_SWAP: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            status_out_q <= status_q;
            count_out_q  <= count_q;
            read_value_q <= (req_q == isl_pkg::REQ_GET && status_q == isl_pkg::ST_DONE)
                            ? rd_wide[isl_pkg::ValueW-1:0] : '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_out_q;
  assign count_o      = count_out_q;

endmodule

@@ design/isl_cell.sv @@
// One list cell: holds a single entry and updates it from the broadcast command.
module isl_cell (
  input  logic                              clk_i,
  input  logic [isl_pkg::CmpW-1:0]          pos_i,
  input  isl_pkg::cmd_t                     cmd_i,
  input  logic [isl_pkg::WordWidth-1:0]     prev_i,
  input  logic [isl_pkg::WordWidth-1:0]     next_i,
  output logic [isl_pkg::WordWidth-1:0]     data_o,
  output logic [isl_pkg::WordWidth-1:0]     rd_a_o,
  output logic [isl_pkg::WordWidth-1:0]     rd_b_o
);

  logic [isl_pkg::WordWidth-1:0] data_q, data_d;
  logic hit_a, hit_b, above_a;

  assign hit_a   = (pos_i == cmd_i.idx_a);
  assign hit_b   = (pos_i == cmd_i.idx_b);
  assign above_a = (pos_i > cmd_i.idx_a);

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.kind)
      isl_pkg::CMD_WRITE: begin
        if (hit_a) data_d = cmd_i.val_a;
      end
      isl_pkg::CMD_INSERT: begin
        if (above_a) data_d = prev_i;
        else if (hit_a) data_d = cmd_i.val_a;
      end
      isl_pkg::CMD_REMOVE: begin
        if (above_a || hit_a) data_d = next_i;
      end
      isl_pkg::CMD_SWAP: begin
        if (hit_a) data_d = cmd_i.val_a;
        else if (hit_b) data_d = cmd_i.val_b;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_a_o = hit_a ? data_q : '0;
  assign rd_b_o = hit_b ? data_q : '0;

endmodule

@@ design/isl_row.sv @@
// Row of list cells chained to their neighbors, with the two indexed read buses.
module isl_row (
  input  logic                          clk_i,
  input  isl_pkg::cmd_t                 cmd_i,
  output logic [isl_pkg::WordWidth-1:0] rd_a_o,
  output logic [isl_pkg::WordWidth-1:0] rd_b_o
);

  logic [isl_pkg::WordWidth-1:0] data  [isl_pkg::Depth];
  logic [isl_pkg::WordWidth-1:0] prev  [isl_pkg::Depth];
  logic [isl_pkg::WordWidth-1:0] next  [isl_pkg::Depth];
  logic [isl_pkg::WordWidth-1:0] rd_a  [isl_pkg::Depth];
  logic [isl_pkg::WordWidth-1:0] rd_b  [isl_pkg::Depth];

  for (genvar g = 0; g < isl_pkg::Depth; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev[g] = '0;
    end else begin : g_mid
      assign prev[g] = data[g-1];
    end
    if (g == isl_pkg::Depth - 1) begin : g_last
      assign next[g] = data[g];
    end else begin : g_inner
      assign next[g] = data[g+1];
    end

    isl_cell u_cell (
      .clk_i  (clk_i),
      .pos_i  (isl_pkg::CmpW'(g)),
      .cmd_i  (cmd_i),
      .prev_i (prev[g]),
      .next_i (next[g]),
      .data_o (data[g]),
      .rd_a_o (rd_a[g]),
      .rd_b_o (rd_b[g])
    );
  end

  // At most one cell matches each index, so an OR of all cells selects it.
  always_comb begin
    rd_a_o = '0;
    rd_b_o = '0;
    for (int i = 0; i < isl_pkg::Depth; i++) begin
      rd_a_o = rd_a_o | rd_a[i];
      rd_b_o = rd_b_o | rd_b[i];
    end
  end

endmodule

@@ design/isl_checker.sv @@
// Port-level checks of the indexed shifting list, bound to its top level.
`include "indexed_shifting_list_core_macros.svh"

module isl_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [isl_pkg::ReqW-1:0]   req_type_i,
  input logic [isl_pkg::IdxW-1:0]   index_i,
  input logic [isl_pkg::IdxW-1:0]   index_b_i,
  input logic [isl_pkg::ValueW-1:0] value_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [isl_pkg::ValueW-1:0] read_value_o,
  input logic [isl_pkg::StW-1:0]    status_o,
  input logic [isl_pkg::CntW-1:0]   count_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o && (req_type_i == req_type_i)
                   && (index_i == index_i) && (index_b_i == index_b_i)
                   && (value_i == value_i);

  // The control works on one request at a time.
  `ISL_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "request taken while busy")

  // The live count never passes the capacity.
  `ISL_ASSERT_NOW(a_count_bound, out_valid_o, 32'(count_o) <= 32'(isl_pkg::Depth), "count beyond capacity")

  // A dropped request is reported only on a full list.
  `ISL_ASSERT_NOW(a_full_status, out_valid_o && status_o == isl_pkg::ST_FULL, 32'(count_o) == 32'(isl_pkg::Depth), "full status on a list that is not full")

  // A stalled result stays in place.
  `ISL_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i, out_valid_o && $stable(read_value_o) && $stable(status_o) && $stable(count_o), "stalled result changed")

endmodule

bind indexed_shifting_list_core isl_checker u_isl_checker (.*);
